// File: hw/rtl/stls_pkg.sv
// package for the sparse triangular level scheduler
// level and index types and the saturation limit; no dependencies
`timescale 1ns / 1ps

package stls_pkg;

  localparam int IDX_W   = 10;
  localparam int LEVEL_W = 10;

  typedef logic [IDX_W-1:0]   idx_t;
  typedef logic [LEVEL_W-1:0] level_t;

  localparam level_t LEVEL_MAX = {LEVEL_W{1'b1}};

endpackage

// File: hw/rtl/stls_item_if.sv
// channel for incoming matrix entries and row end markers
// depends on stls_pkg
`timescale 1ns / 1ps

interface stls_item_if;
  logic          valid;
  logic          ready;
  stls_pkg::idx_t row_index;
  stls_pkg::idx_t col_index;
  logic          entry_valid;
  logic          row_end;

  modport source (output valid, output row_index, output col_index,
                  output entry_valid, output row_end, input ready);
  modport sink   (input valid, input row_index, input col_index,
                  input entry_valid, input row_end, output ready);
endinterface

// File: hw/rtl/stls_result_if.sv
// channel for reported row levels
// depends on stls_pkg
`timescale 1ns / 1ps

interface stls_result_if;
  logic            valid;
  logic            ready;
  stls_pkg::idx_t   node;
  stls_pkg::level_t level;

  modport source (output valid, output node, output level, input ready);
  modport sink   (input valid, input node, input level, output ready);
endinterface

// File: hw/rtl/stls_level_ram.sv
// per-row level store: one write port, one read port, registered read data
// depends on stls_pkg
`timescale 1ns / 1ps

module stls_level_ram #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  stls_pkg::level_t wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output stls_pkg::level_t rdata
);

  stls_pkg::level_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: hw/rtl/sparse_triangular_level_schedule.sv
// top level of the sparse triangular level scheduler
// depends on stls_pkg, stls_item_if, stls_result_if, stls_level_ram
//
//  channel  | dir | payload                                   | transaction
//  ---------+-----+-------------------------------------------+----------------------
//  item     | in  | row_index, col_index, entry_valid, row_end | one entry or row end
//  result   | out | node, level                               | one finished row
//
// one item per cycle sustained while the result is not stalled; an item passes the
// level store read and then the update stage, and a row's level is registered into
// the result as its row end item leaves that stage. a write of the just-finished row
// is forwarded to a read issued in the same cycle. rst clears the pipeline, running
// level and output valid; the store itself is not cleared. a stalled result holds the
// update stage, and the item channel stalls with it only when that stage holds a row end.
`timescale 1ns / 1ps

module sparse_triangular_level_schedule #(
  parameter int MAX_NODES = 1024
) (
  input logic           clk,
  input logic           rst,
  stls_item_if.sink     item,
  stls_result_if.source result
);

  localparam int AW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;

  logic             accept;
  logic             in_dep;
  logic [AW-1:0]    rd_addr;
  stls_pkg::level_t mem_q;

  logic             s1_valid;
  stls_pkg::idx_t   s1_row;
  logic             s1_dep;
  logic             s1_last;
  logic             fwd_hit;
  stls_pkg::level_t fwd_data;
  stls_pkg::level_t running_level;

  logic             s1_go;
  logic             s1_fire;
  stls_pkg::level_t dep_level;
  stls_pkg::level_t cand;
  stls_pkg::level_t run_next;
  logic             wr_en;
  logic [AW-1:0]    wr_addr;

  assign s1_go      = !s1_last || !result.valid || result.ready;
  assign s1_fire    = s1_valid && s1_go;
  assign item.ready = !s1_valid || s1_go;
  assign accept     = item.valid && item.ready;

  assign in_dep = item.entry_valid && (item.col_index < item.row_index) &&
                  ({22'd0, item.col_index} < 32'(MAX_NODES));
  assign rd_addr = AW'(item.col_index);

  // update stage: pick forwarded data when the read raced a write
  assign dep_level = fwd_hit ? fwd_data : mem_q;
  assign cand      = (dep_level == stls_pkg::LEVEL_MAX) ? stls_pkg::LEVEL_MAX
                                                        : dep_level + 1'b1;
  assign run_next  = (s1_dep && cand > running_level) ? cand : running_level;

  assign wr_en   = s1_fire && s1_last && ({22'd0, s1_row} < 32'(MAX_NODES));
  assign wr_addr = AW'(s1_row);

  stls_level_ram #(
    .DEPTH (MAX_NODES),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (run_next),
    .re    (accept),
    .raddr (rd_addr),
    .rdata (mem_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid      <= 1'b0;
      running_level <= '0;
      result.valid  <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid <= 1'b1;
      end else if (s1_fire) begin
        s1_valid <= 1'b0;
      end

      if (s1_fire) begin
        running_level <= s1_last ? '0 : run_next;
      end

      if (s1_fire && s1_last) begin
        result.valid <= 1'b1;
      end else if (result.ready) begin
        result.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_row   <= item.row_index;
      s1_dep   <= in_dep;
      s1_last  <= item.row_end;
      fwd_hit  <= wr_en && (wr_addr == rd_addr);
      fwd_data <= run_next;
    end
    if (s1_fire && s1_last) begin
      result.node  <= s1_row;
      result.level <= run_next;
    end
  end

  a_row_end_clears: assert property (@(posedge clk) disable iff (rst)
    s1_fire && s1_last |=> running_level == '0)
    else $error("running level not cleared after row end");

  a_level_monotonic: assert property (@(posedge clk) disable iff (rst)
    s1_fire && !s1_last |=> running_level >= $past(running_level))
    else $error("running level decreased within a row");

  a_write_reported: assert property (@(posedge clk) disable iff (rst)
    wr_en |=> result.valid && result.level == $past(run_next))
    else $error("stored level not reported");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s1_go |=> s1_valid && $stable(s1_row))
    else $error("update stage lost an item while stalled");

endmodule
